// File: src/tick_counter_realtime_clock_defines.svh
// ----------------------------------------------------------------------------
// Tick counter real-time clock: assertion macros
// Shared property wrappers for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef TICK_COUNTER_REALTIME_CLOCK_DEFINES_SVH
`define TICK_COUNTER_REALTIME_CLOCK_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define TRTC_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define TRTC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/trtc_pkg.sv
// ----------------------------------------------------------------------------
// Tick counter real-time clock: package
// Widths, constants, codes and controller/datapath signal groups.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package trtc_pkg;

	// Width of the free-running hardware counter (16 to 32).
	localparam int COUNTER_WIDTH = 32;

	localparam int TICK_W     = 64;
	localparam int FREQ_W     = 32;
	localparam int SEC_W      = 32;
	localparam int USEC_W     = 20;
	localparam int CNT_IN_W   = 32;
	localparam int PROD_W     = FREQ_W + USEC_W;
	localparam int DIV_W      = TICK_W;
	localparam int STEP_CNT_W = $clog2(DIV_W + 1);
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 32;

	localparam logic [USEC_W-1:0] USEC_PER_SEC = USEC_W'(1000000);
	localparam logic [FREQ_W-1:0] FREQ_RESET   = FREQ_W'(80000000);

	typedef enum logic [1:0] {
		KIND_SAMPLE = 2'd0,
		KIND_SET    = 2'd1,
		KIND_GET    = 2'd2,
		KIND_NONE   = 2'd3
	} trtc_kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FREQ = 1'b0,
		CFG_BG   = 1'b1
	} trtc_cfg_idx_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic start_div1;
		logic step;
		logic mul;
		logic start_div2;
		logic finish;
	} trtc_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic freq_zero;
		logic div_last;
	} trtc_sts_t;

endpackage

// File: src/trtc_if.sv
// ----------------------------------------------------------------------------
// Tick counter real-time clock: channel interfaces
// Valid/ready channels for input items, results and register writes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface trtc_item_if
	import trtc_pkg::*;
();
	logic                valid;
	logic                ready;
	trtc_kind_t          kind;
	logic [CNT_IN_W-1:0] counter_now;
	logic [SEC_W-1:0]    set_seconds;

	modport source(output valid, kind, counter_now, set_seconds, input ready);
	modport sink(input valid, kind, counter_now, set_seconds, output ready);
endinterface

interface trtc_result_if
	import trtc_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [SEC_W-1:0]  seconds;
	logic [USEC_W-1:0] microseconds;

	modport source(output valid, seconds, microseconds, input ready);
	modport sink(input valid, seconds, microseconds, output ready);
endinterface

interface trtc_cfg_if
	import trtc_pkg::*;
();
	logic                  valid;
	logic                  ready;
	trtc_cfg_idx_t         index;
	logic [CFG_DATA_W-1:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// File: src/tick_counter_realtime_clock.sv
// ----------------------------------------------------------------------------
// Tick counter real-time clock: top level
// Sample and set items complete on acceptance; a get item presents its result
// after 64 divider steps for the seconds, one multiply, 52 divider steps for
// the microseconds and three sequencing states.
// One single-bit restoring divider serves both divisions; one item is in work at a
// time, and a waiting result does not block the next item. Reset clears the
// tick count, time base and handshakes and reloads both registers' defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// The block extends a free-running hardware counter to a 64-bit tick count.
// Every item can refresh that count: when the new counter sample is smaller
// than the stored low word, the counter is assumed to have wrapped exactly
// once, so samples must arrive more often than one counter period.
//
// A set item captures the current tick count as the time base together with
// the new second count. A get item computes the ticks elapsed since the base
// and divides them by the clock frequency in a shared bit-serial divider. The
// quotient, added to the base seconds, gives the whole seconds; the remainder
// is multiplied by one million and divided again to give the microseconds.
// With a frequency of zero the get returns the base seconds and no fraction.
//
// The controller owns the handshakes and sequencing; the datapath owns every
// stored value. The result sits in an output register, so the next request
// can be accepted while a finished result still waits on the result channel.
// Register writes are always accepted and are expected only while idle.
module tick_counter_realtime_clock
	import trtc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	trtc_item_if.sink     item,
	trtc_result_if.source result,
	trtc_cfg_if.sink      cfg
);

	trtc_cmd_t cmd;
	trtc_sts_t sts;

	// Configuration writes are always accepted and are registered in the datapath.
	assign cfg.ready = 1'b1;

	trtc_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item.valid),
		.item_kind    (item.kind),
		.item_ready   (item.ready),
		.result_valid (result.valid),
		.result_ready (result.ready),
		.cmd          (cmd),
		.sts          (sts)
	);

	trtc_dp u_dp (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cmd                 (cmd),
		.sts                 (sts),
		.item_kind           (item.kind),
		.item_counter_now    (item.counter_now),
		.item_set_seconds    (item.set_seconds),
		.cfg_write           (cfg.valid),
		.cfg_index           (cfg.index),
		.cfg_data            (cfg.data),
		.result_seconds      (result.seconds),
		.result_microseconds (result.microseconds)
	);

endmodule

// File: src/trtc_ctrl.sv
// ----------------------------------------------------------------------------
// Tick counter real-time clock: controller
// Sequences item acceptance, the two divisions and the result handoff.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module trtc_ctrl
	import trtc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	input  trtc_kind_t item_kind,
	output logic       item_ready,
	output logic       result_valid,
	input  logic       result_ready,
	output trtc_cmd_t  cmd,
	input  trtc_sts_t  sts
);

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_START1 = 7'b0000010,
		ST_DIV1   = 7'b0000100,
		ST_MUL    = 7'b0001000,
		ST_START2 = 7'b0010000,
		ST_DIV2   = 7'b0100000,
		ST_DONE   = 7'b1000000
	} trtc_state_t;

	trtc_state_t state_q;
	trtc_state_t state_nxt;
	logic        result_valid_q;

	always_comb begin
		cmd        = '0;
		state_nxt  = state_q;
		item_ready = (state_q == ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					cmd.accept = 1'b1;
					if (item_kind == KIND_GET) begin
						state_nxt = ST_START1;
					end
				end
			end
			ST_START1: begin
				if (sts.freq_zero) begin
					state_nxt = ST_DONE;
				end else begin
					cmd.start_div1 = 1'b1;
					state_nxt      = ST_DIV1;
				end
			end
			ST_DIV1: begin
				cmd.step = 1'b1;
				if (sts.div_last) begin
					state_nxt = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul   = 1'b1;
				state_nxt = ST_START2;
			end
			ST_START2: begin
				cmd.start_div2 = 1'b1;
				state_nxt      = ST_DIV2;
			end
			ST_DIV2: begin
				cmd.step = 1'b1;
				if (sts.div_last) begin
					state_nxt = ST_DONE;
				end
			end
			ST_DONE: begin
				// Wait until the output register is free or is being emptied.
				if (!result_valid_q || result_ready) begin
					cmd.finish = 1'b1;
					state_nxt  = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.finish) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	assign result_valid = result_valid_q;

endmodule

// File: src/trtc_dp.sv
// ----------------------------------------------------------------------------
// Tick counter real-time clock: datapath
// Tick extension, time base, shared restoring divider and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module trtc_dp
	import trtc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  trtc_cmd_t             cmd,
	output trtc_sts_t             sts,
	input  trtc_kind_t            item_kind,
	input  logic [CNT_IN_W-1:0]   item_counter_now,
	input  logic [SEC_W-1:0]      item_set_seconds,
	input  logic                  cfg_write,
	input  trtc_cfg_idx_t         cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic [SEC_W-1:0]      result_seconds,
	output logic [USEC_W-1:0]     result_microseconds
);

	logic [FREQ_W-1:0]     freq_q;
	logic                  bg_q;
	logic [TICK_W-1:0]     ext_q;
	logic [TICK_W-1:0]     base_q;
	logic [SEC_W-1:0]      base_sec_q;

	logic [DIV_W-1:0]      num_q;
	logic [FREQ_W-1:0]     rem_q;
	logic [STEP_CNT_W-1:0] cnt_q;
	logic [PROD_W-1:0]     prod_q;
	logic [SEC_W-1:0]      secs_hold_q;
	logic [SEC_W-1:0]      seconds_q;
	logic [USEC_W-1:0]     usec_q;

	logic [COUNTER_WIDTH-1:0] now;
	logic                     wrap;
	logic [TICK_W-1:0]        refreshed;
	logic [TICK_W-1:0]        ext_upd;
	logic [FREQ_W:0]          partial;
	logic [FREQ_W:0]          trial;
	logic                     fits;

	// A sample below the stored low word means the counter wrapped once.
	always_comb begin
		now       = item_counter_now[COUNTER_WIDTH-1:0];
		wrap      = (ext_q[COUNTER_WIDTH-1:0] > now);
		refreshed = {ext_q[TICK_W-1:COUNTER_WIDTH] + (TICK_W-COUNTER_WIDTH)'(wrap), now};
		if (item_kind == KIND_SAMPLE ||
			(!bg_q && (item_kind == KIND_SET || item_kind == KIND_GET))) begin
			ext_upd = refreshed;
		end else begin
			ext_upd = ext_q;
		end
	end

	// One restoring step: shift in the next dividend bit, subtract if it fits.
	always_comb begin
		partial = {rem_q, num_q[DIV_W-1]};
		trial   = partial - {1'b0, freq_q};
		fits    = (partial >= {1'b0, freq_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freq_q     <= FREQ_RESET;
			bg_q       <= 1'b0;
			ext_q      <= '0;
			base_q     <= '0;
			base_sec_q <= '0;
			cnt_q      <= '0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					CFG_FREQ: freq_q <= cfg_data[FREQ_W-1:0];
					CFG_BG:   bg_q   <= cfg_data[0];
					default:  freq_q <= freq_q;
				endcase
			end
			if (cmd.accept) begin
				ext_q <= ext_upd;
				if (item_kind == KIND_SET) begin
					base_q     <= ext_upd;
					base_sec_q <= item_set_seconds;
				end
			end
			if (cmd.start_div1) begin
				cnt_q <= STEP_CNT_W'(DIV_W);
			end else if (cmd.start_div2) begin
				cnt_q <= STEP_CNT_W'(PROD_W);
			end else if (cmd.step) begin
				cnt_q <= cnt_q - STEP_CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start_div1) begin
			num_q <= ext_q - base_q;
			rem_q <= '0;
		end else if (cmd.start_div2) begin
			// Left-align the scaled remainder so only its bits are stepped through.
			num_q <= {prod_q, {(DIV_W-PROD_W){1'b0}}};
			rem_q <= '0;
		end else if (cmd.step) begin
			num_q <= {num_q[DIV_W-2:0], fits};
			rem_q <= fits ? trial[FREQ_W-1:0] : partial[FREQ_W-1:0];
		end
		if (cmd.mul) begin
			prod_q      <= PROD_W'(rem_q) * PROD_W'(USEC_PER_SEC);
			secs_hold_q <= base_sec_q + num_q[SEC_W-1:0];
		end
		if (cmd.finish) begin
			if (freq_q == '0) begin
				seconds_q <= base_sec_q;
				usec_q    <= '0;
			end else begin
				seconds_q <= secs_hold_q;
				usec_q    <= num_q[USEC_W-1:0];
			end
		end
	end

	assign sts.freq_zero       = (freq_q == '0);
	assign sts.div_last        = (cnt_q == STEP_CNT_W'(1));
	assign result_seconds      = seconds_q;
	assign result_microseconds = usec_q;

endmodule

// File: src/trtc_checker.sv
// ----------------------------------------------------------------------------
// Tick counter real-time clock: port checker
// Properties over the top-level handshakes and results, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "tick_counter_realtime_clock_defines.svh"

module trtc_checker
	import trtc_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              item_valid,
	input logic              item_ready,
	input trtc_kind_t        item_kind,
	input logic              result_valid,
	input logic              result_ready,
	input logic [SEC_W-1:0]  result_seconds,
	input logic [USEC_W-1:0] result_microseconds
);

	// A stalled result keeps its value.
	`TRTC_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result_seconds) && $stable(result_microseconds), "result changed while stalled")

	// The fraction of a second always stays below one million microseconds.
	`TRTC_ASSERT_SAME(a_usec_range, result_valid, result_microseconds < USEC_PER_SEC, "microseconds out of range")

	// No result can appear in the cycle after a request is accepted.
	`TRTC_ASSERT_NEXT(a_no_instant_result, item_valid && item_ready && !result_valid, !result_valid, "result appeared right after a request")

	// A get request occupies the block, so no request follows it directly.
	`TRTC_ASSERT_NEXT(a_get_busy, item_valid && item_ready && item_kind == KIND_GET, !item_ready, "ready stayed high after a get request")

endmodule

bind tick_counter_realtime_clock trtc_checker u_trtc_checker (
	.clk                 (clk),
	.arst_n              (arst_n),
	.item_valid          (item.valid),
	.item_ready          (item.ready),
	.item_kind           (item.kind),
	.result_valid        (result.valid),
	.result_ready        (result.ready),
	.result_seconds      (result.seconds),
	.result_microseconds (result.microseconds)
);
